// File: rtl/pid_speed_controller_defines.svh
// Assertion shorthands shared by the checker of the speed controller.
`ifndef PID_SPEED_CONTROLLER_DEFINES_SVH
`define PID_SPEED_CONTROLLER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIDSC_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PIDSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/pidsc_pkg.sv
`default_nettype none

package pidsc_pkg;

   // Field widths.
   localparam int SPEED_W     = 16;
   localparam int ERR_W       = SPEED_W + 1;
   localparam int DIFF_W      = ERR_W + 1;
   localparam int DERIV_W     = DIFF_W + 1;
   localparam int GAIN_W      = 24;
   localparam int LIMIT_W     = 15;
   localparam int VOLT_W      = 16;
   localparam int INTEG_W     = 32;

   // Serial multiply-accumulate: upper accumulator half plus one gain bit per step.
   localparam int HI_W        = INTEG_W + 3;
   localparam int ACC_W       = HI_W + GAIN_W;
   localparam int ROUND_SHIFT = 12;
   localparam int V_W         = ACC_W - ROUND_SHIFT;
   localparam int CNT_W       = $clog2(GAIN_W);

   // Configuration channel.
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = GAIN_W;

   localparam logic [GAIN_W-1:0]  PROP_GAIN_RESET  = 24'd67109;
   localparam logic [GAIN_W-1:0]  INTEG_GAIN_RESET = 24'd336;
   localparam logic [GAIN_W-1:0]  DERIV_GAIN_RESET = 24'd0;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET      = 15'd13517;

   // Half an output LSB in accumulator units, for round half up.
   localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(2048);

   // The output never reaches the most negative code, since the limit is at most 32767.
   localparam logic signed [VOLT_W-1:0] VOLT_MOST_NEG = {1'b1, {(VOLT_W-1){1'b0}}};

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PROP_GAIN     = 8'd0,
      CSR_INTEG_GAIN    = 8'd1,
      CSR_DERIV_GAIN    = 8'd2,
      CSR_VOLTAGE_LIMIT = 8'd3
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0] prop;
      logic [GAIN_W-1:0] integ;
      logic [GAIN_W-1:0] deriv;
   } gain_set_type;

   typedef struct packed {
      logic signed [ERR_W-1:0]   err;
      logic signed [DERIV_W-1:0] deriv;
      logic signed [INTEG_W-1:0] cand;
   } mac_operand_type;

endpackage

`default_nettype wire

// File: rtl/pidsc_channels.sv
`default_nettype none

// Sample channel: one transfer per sampling instant.
interface pidsc_req_if;
   import pidsc_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [SPEED_W-1:0] target_speed;
   logic signed [SPEED_W-1:0] measured_speed;

   modport source (output valid, target_speed, measured_speed, input ready);
   modport sink (input valid, target_speed, measured_speed, output ready);
endinterface

// Result channel: one transfer per sample.
interface pidsc_rsp_if;
   import pidsc_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [VOLT_W-1:0] drive_voltage;
   logic                     clamped;

   modport source (output valid, drive_voltage, clamped, input ready);
   modport sink (input valid, drive_voltage, clamped, output ready);
endinterface

// Register write channel.
interface pidsc_csr_if;
   import pidsc_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/pidsc_mac.sv
`default_nettype none

// Bit-serial multiply-accumulate of three signed operands by three unsigned gains.
// One bit of every gain is consumed per cycle, LSB first; the partial sum shifts
// right so the adder stays HI_W bits wide.
module pidsc_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  pidsc_pkg::mac_operand_type          operand,
   input  pidsc_pkg::gain_set_type             gains,
   output logic                                done,
   output logic signed [pidsc_pkg::ACC_W-1:0]  acc
);
   import pidsc_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   gain_set_type            gain_ff, gain_in;
   mac_operand_type         op_ff, op_in;
   logic signed [HI_W-1:0]  hi_ff, hi_in;
   logic [GAIN_W-1:0]       lo_ff, lo_in;
   logic signed [HI_W-1:0]  addend;
   logic signed [HI_W-1:0]  part_sum;

   // Select the operands whose gain bit is set and add them to the upper half.
   always_comb begin
      addend = '0;
      if (gain_ff.prop[0]) begin
         addend = addend + HI_W'(op_ff.err);
      end
      if (gain_ff.deriv[0]) begin
         addend = addend + HI_W'(op_ff.deriv);
      end
      if (gain_ff.integ[0]) begin
         addend = addend + HI_W'(op_ff.cand);
      end
      part_sum = hi_ff + addend;
   end

   // Load on start, then shift one gain bit per cycle.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      gain_in = gain_ff;
      op_in   = op_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         gain_in = gains;
         op_in   = operand;
         hi_in   = '0;
         lo_in   = '0;
      end else if (busy_ff) begin
         hi_in         = part_sum >>> 1;
         lo_in         = {part_sum[0], lo_ff[GAIN_W-1:1]};
         gain_in.prop  = gain_ff.prop >> 1;
         gain_in.integ = gain_ff.integ >> 1;
         gain_in.deriv = gain_ff.deriv >> 1;
         cnt_in        = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(GAIN_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      gain_ff <= gain_in;
      op_ff   <= op_in;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
   end

   assign done = done_ff;
   assign acc  = {hi_ff, lo_ff};

endmodule

`default_nettype wire

// File: rtl/pid_speed_controller.sv
// PID speed controller. Each transfer on req_ch is one sampling instant; the block
// answers it with exactly one transfer on rsp_ch carrying the clamped drive voltage
// in Q4.12 and a flag that tells whether the limit was hit (in which case the
// integral keeps its previous value). A sample passes through S_STEP, S_DIV, S_MUL,
// S_ROUND and S_DONE, and the next sample is taken only back in S_IDLE: an 18-step
// restoring divider forms the derivative and a 24-step bit-serial multiply-accumulate
// applies the three gains, one gain bit per cycle. A result waiting on rsp_ch does
// not hold off the next sample; only its final state, S_DONE, waits for the result
// register to be free. The user must write registers on csr_ch only while no sample
// is in flight; the block does not enforce this. csr_ch is always ready.
`default_nettype none

module pid_speed_controller #(
   parameter int unsigned SAMPLE_PERIOD = 10
) (
   input  logic         clock,
   input  logic         reset,
   pidsc_req_if.sink    req_ch,
   pidsc_rsp_if.source  rsp_ch,
   pidsc_csr_if.sink    csr_ch
);
   import pidsc_pkg::*;

   localparam int PERIOD_W = $clog2(SAMPLE_PERIOD + 1);
   localparam int TRIAL_W  = PERIOD_W + 1;
   localparam int STEP_W   = DIFF_W + PERIOD_W + 1;
   localparam int SUM_W    = INTEG_W + 2;

   localparam logic signed [STEP_W-1:0]  PERIOD_S  = STEP_W'(SAMPLE_PERIOD);
   localparam logic [TRIAL_W-1:0]        PERIOD_T  = TRIAL_W'(SAMPLE_PERIOD);
   localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
   localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

   typedef enum logic [2:0] {
      S_IDLE,
      S_STEP,
      S_DIV,
      S_MUL,
      S_ROUND,
      S_DONE
   } state_type;

   state_type                  state_ff, state_in;
   logic [GAIN_W-1:0]          prop_gain_ff, prop_gain_in;
   logic [GAIN_W-1:0]          integ_gain_ff, integ_gain_in;
   logic [GAIN_W-1:0]          deriv_gain_ff, deriv_gain_in;
   logic [LIMIT_W-1:0]         limit_ff, limit_in;
   logic signed [ERR_W-1:0]    prev_err_ff, prev_err_in;
   logic signed [INTEG_W-1:0]  integ_ff, integ_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       mac_start_ff, mac_start_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       neg_ff, neg_in;

   logic signed [ERR_W-1:0]    err_ff, err_in;
   logic signed [STEP_W-1:0]   step_ff, step_in;
   logic signed [INTEG_W-1:0]  cand_ff, cand_in;
   logic [PERIOD_W-1:0]        rem_ff, rem_in;
   logic [DIFF_W-1:0]          dvd_ff, dvd_in;
   logic signed [DERIV_W-1:0]  deriv_ff, deriv_in;
   logic signed [V_W-1:0]      v_ff, v_in;
   logic signed [VOLT_W-1:0]   volt_ff, volt_in;
   logic                       clamp_ff, clamp_in;

   logic signed [DIFF_W-1:0]   err_sum;
   logic signed [DIFF_W-1:0]   err_diff;
   logic signed [STEP_W-1:0]   step_prod;
   logic signed [SUM_W-1:0]    integ_sum;
   logic [TRIAL_W-1:0]         trial;
   logic                       quot_bit;
   logic [PERIOD_W-1:0]        rem_next;
   logic [DIFF_W-1:0]          quot;
   logic signed [ACC_W-1:0]    rounded;
   logic signed [V_W-1:0]      v_lim;
   logic signed [V_W-1:0]      v_neg_lim;
   logic                       rsp_free;

   mac_operand_type            mac_operand;
   gain_set_type               mac_gains;
   logic                       mac_done;
   logic signed [ACC_W-1:0]    mac_acc;

   assign mac_operand = '{err: err_ff, deriv: deriv_ff, cand: cand_ff};
   assign mac_gains   = '{prop: prop_gain_ff, integ: integ_gain_ff, deriv: deriv_gain_ff};

   pidsc_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .start   (mac_start_ff),
      .operand (mac_operand),
      .gains   (mac_gains),
      .done    (mac_done),
      .acc     (mac_acc)
   );

   // Datapath terms shared by the states.
   always_comb begin
      err_sum   = DIFF_W'(err_ff) + DIFF_W'(prev_err_ff);
      err_diff  = DIFF_W'(err_ff) - DIFF_W'(prev_err_ff);
      step_prod = STEP_W'(err_sum) * PERIOD_S;
      integ_sum = SUM_W'(integ_ff) + SUM_W'(step_ff);
      trial     = {rem_ff, dvd_ff[DIFF_W-1]};
      quot_bit  = (trial >= PERIOD_T);
      rem_next  = quot_bit ? PERIOD_W'(trial - PERIOD_T) : trial[PERIOD_W-1:0];
      quot      = {dvd_ff[DIFF_W-2:0], quot_bit};
      rounded   = mac_acc + ROUND_BIAS;
      v_lim     = V_W'({1'b0, limit_ff});
      v_neg_lim = -v_lim;
      rsp_free  = !rsp_valid_ff || rsp_ch.ready;
   end

   // Next-state logic for the sequencer, the registers and the result.
   always_comb begin
      state_in      = state_ff;
      prop_gain_in  = prop_gain_ff;
      integ_gain_in = integ_gain_ff;
      deriv_gain_in = deriv_gain_ff;
      limit_in      = limit_ff;
      prev_err_in   = prev_err_ff;
      integ_in      = integ_ff;
      rsp_valid_in  = rsp_valid_ff;
      mac_start_in  = 1'b0;
      cnt_in        = cnt_ff;
      neg_in        = neg_ff;
      err_in        = err_ff;
      step_in       = step_ff;
      cand_in       = cand_ff;
      rem_in        = rem_ff;
      dvd_in        = dvd_ff;
      deriv_in      = deriv_ff;
      v_in          = v_ff;
      volt_in       = volt_ff;
      clamp_in      = clamp_ff;

      // Register writes; unknown indexes are dropped.
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_PROP_GAIN:     prop_gain_in  = csr_ch.data[GAIN_W-1:0];
            CSR_INTEG_GAIN:    integ_gain_in = csr_ch.data[GAIN_W-1:0];
            CSR_DERIV_GAIN:    deriv_gain_in = csr_ch.data[GAIN_W-1:0];
            CSR_VOLTAGE_LIMIT: limit_in      = csr_ch.data[LIMIT_W-1:0];
            default: ;
         endcase
      end

      // A result transfer empties the output register.
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               err_in   = ERR_W'(req_ch.target_speed) - ERR_W'(req_ch.measured_speed);
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            // Trapezoid step, floored, and divider setup on the error change.
            step_in  = step_prod >>> 1;
            neg_in   = err_diff[DIFF_W-1];
            dvd_in   = err_diff[DIFF_W-1] ? DIFF_W'(-err_diff) : DIFF_W'(err_diff);
            rem_in   = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            // Saturated integral candidate; step_ff is stable through this state.
            if (integ_sum > SUM_W'(INTEG_MAX)) begin
               cand_in = INTEG_MAX;
            end else if (integ_sum < SUM_W'(INTEG_MIN)) begin
               cand_in = INTEG_MIN;
            end else begin
               cand_in = integ_sum[INTEG_W-1:0];
            end
            // One quotient bit per cycle; the sign is applied at the end.
            rem_in = rem_next;
            dvd_in = quot;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIFF_W - 1)) begin
               deriv_in     = neg_ff ? DERIV_W'(0) - DERIV_W'(quot) : DERIV_W'(quot);
               mac_start_in = 1'b1;
               state_in     = S_MUL;
            end
         end
         S_MUL: begin
            if (mac_done) begin
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            v_in     = rounded[ACC_W-1:ROUND_SHIFT];
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               // Clamp the rounded value; the integral holds while clamped.
               if (v_ff > v_lim) begin
                  volt_in  = VOLT_W'(v_lim);
                  clamp_in = 1'b1;
               end else if (v_ff < v_neg_lim) begin
                  volt_in  = VOLT_W'(v_neg_lim);
                  clamp_in = 1'b1;
               end else begin
                  volt_in  = VOLT_W'(v_ff);
                  clamp_in = 1'b0;
                  integ_in = cand_ff;
               end
               prev_err_in  = err_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         prop_gain_ff  <= PROP_GAIN_RESET;
         integ_gain_ff <= INTEG_GAIN_RESET;
         deriv_gain_ff <= DERIV_GAIN_RESET;
         limit_ff      <= LIMIT_RESET;
         prev_err_ff   <= '0;
         integ_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         mac_start_ff  <= 1'b0;
         cnt_ff        <= '0;
         neg_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prop_gain_ff  <= prop_gain_in;
         integ_gain_ff <= integ_gain_in;
         deriv_gain_ff <= deriv_gain_in;
         limit_ff      <= limit_in;
         prev_err_ff   <= prev_err_in;
         integ_ff      <= integ_in;
         rsp_valid_ff  <= rsp_valid_in;
         mac_start_ff  <= mac_start_in;
         cnt_ff        <= cnt_in;
         neg_ff        <= neg_in;
      end
      err_ff   <= err_in;
      step_ff  <= step_in;
      cand_ff  <= cand_in;
      rem_ff   <= rem_in;
      dvd_ff   <= dvd_in;
      deriv_ff <= deriv_in;
      v_ff     <= v_in;
      volt_ff  <= volt_in;
      clamp_ff <= clamp_in;
   end

   assign req_ch.ready         = (state_ff == S_IDLE);
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.drive_voltage = volt_ff;
   assign rsp_ch.clamped       = clamp_ff;
   assign csr_ch.ready         = 1'b1;

endmodule

`default_nettype wire

// File: rtl/pidsc_checker.sv
`default_nettype none
`include "pid_speed_controller_defines.svh"

// Port-level checks for the speed controller.
module pidsc_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_valid,
   input logic                                    req_ready,
   input logic                                    rsp_valid,
   input logic                                    rsp_ready,
   input logic signed [pidsc_pkg::VOLT_W-1:0]     drive_voltage,
   input logic                                    clamped
);
   import pidsc_pkg::*;

   logic req_xfer;

   assign req_xfer = req_valid && req_ready;

   // Only one sample is in flight: the block stops taking samples after a transfer.
   `PIDSC_ASSERT_NEXT(a_busy_after_req, clock, reset, req_xfer, !req_ready, "sample taken while busy")

   // No result can appear in the cycle right after a sample transfer.
   `PIDSC_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_xfer, !$rose(rsp_valid), "result too early")

   // A stalled result stays put.
   `PIDSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(drive_voltage) && $stable(clamped), "stalled result changed")

   // The clamp never yields the most negative code.
   `PIDSC_ASSERT_HOLDS(a_volt_range, clock, reset, rsp_valid, drive_voltage != VOLT_MOST_NEG, "voltage out of range")

endmodule

bind pid_speed_controller pidsc_checker u_pidsc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .drive_voltage (rsp_ch.drive_voltage),
   .clamped       (rsp_ch.clamped)
);

`default_nettype wire
